// File: src/htsmp_pkg.sv
`default_nettype none
package htsmp_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_CELLS_DEF    = 127;
   localparam int MAX_VERTICES_DEF = 16384;

   // Fixed widths of the datapath.
   localparam int CELL_W   = 8;   // clamped cell count, up to 127
   localparam int STRIDE_W = 9;   // cells + 1
   localparam int ADDR_W   = 16;  // row-major vertex address
   localparam int IDX_W    = 14;  // load slot field
   localparam int H_W      = 32;  // height word
   localparam int WGT_W    = 17;  // Q1.16 weight including 1.0
   localparam int FRAC_W   = 16;  // cell fraction
   localparam int CSR_AW   = 4;   // byte address of three 32-bit registers
   localparam int NCORNER  = 3;   // corners read per sample

   // Register reset values.
   localparam logic [6:0]  GRID_CELLS_RST  = 7'd64;
   localparam logic [30:0] HALF_EXTENT_RST = 31'd0;
   localparam logic [31:0] INV_SPACING_RST = 32'd65536;

   // Weight of one whole vertex.
   localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

   typedef enum logic [1:0] {
      REG_GRID_CELLS  = 2'd0,
      REG_HALF_EXTENT = 2'd1,
      REG_INV_SPACING = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ZERO   = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MULX,
      FR_MULZ,
      FR_CLASS
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RD0,
      BK_RD1,
      BK_RD2,
      BK_MUL2,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [6:0]  grid_cells;
      logic [30:0] half_extent;
      logic [31:0] inv_spacing;
   } cfg_type;

   // Work handed from the front to the back.
   typedef struct packed {
      op_type                           op;
      logic                             outside;
      logic [NCORNER-1:0][ADDR_W-1:0]   addr;
      logic [NCORNER-1:0][WGT_W-1:0]    wgt;
      logic [IDX_W-1:0]                 load_idx;
      logic [H_W-1:0]                   load_data;
   } item_type;

   typedef struct packed {
      logic [H_W-1:0] height;
      logic           outside_grid;
   } result_type;

endpackage
`default_nettype wire

// File: src/heightfield_triangle_sample_top.sv
// A load passes the front and is written by the back in its idle state. A query
// passes the front states MULX and MULZ (two 32x32 products) and CLASS
// (classification), then the back states RD0 to DONE (three corner reads via
// the single store read port, one multiplier); the front can take the next query
// meanwhile. Loads go one per cycle while the front idles with queue room.
// Synchronous reset empties the queues and restores registers, but not the store.
`default_nettype none
module heightfield_triangle_sample_top #(
   parameter int MAX_CELLS    = htsmp_pkg::MAX_CELLS_DEF,
   parameter int MAX_VERTICES = htsmp_pkg::MAX_VERTICES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_mode,
   input  logic [htsmp_pkg::IDX_W-1:0]  req_vertex_index,
   input  logic signed [31:0]           req_vertex_height,
   input  logic signed [31:0]           req_query_x,
   input  logic signed [31:0]           req_query_z,
   output logic                         empty,
   input  logic                         pop,
   output logic signed [31:0]           rsp_height,
   output logic                         rsp_outside_grid,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [htsmp_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import htsmp_pkg::*;

   logic [6:0]    grid_cells_ff;
   logic [30:0]   half_extent_ff;
   logic [31:0]   inv_spacing_ff;
   cfg_type       cfg;
   reg_index_type csr_idx;
   logic          csr_wr;

   item_type      fq_in, fq_out;
   logic          fq_push, fq_full, fq_pop, fq_empty;
   result_type    res_in, res_out;
   logic          res_push, res_full;

   // Register port.
   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_idx)
         REG_GRID_CELLS:  prdata = 32'(grid_cells_ff);
         REG_HALF_EXTENT: prdata = 32'(half_extent_ff);
         REG_INV_SPACING: prdata = inv_spacing_ff;
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cells_ff  <= GRID_CELLS_RST;
         half_extent_ff <= HALF_EXTENT_RST;
         inv_spacing_ff <= INV_SPACING_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GRID_CELLS:  grid_cells_ff  <= pwdata[6:0];
            REG_HALF_EXTENT: half_extent_ff <= pwdata[30:0];
            REG_INV_SPACING: inv_spacing_ff <= pwdata;
            default:         grid_cells_ff  <= grid_cells_ff;
         endcase
      end
   end

   assign cfg = '{grid_cells: grid_cells_ff, half_extent: half_extent_ff,
                  inv_spacing: inv_spacing_ff};

   // Front: accepts words, maps queries to grid cells.
   htsmp_front #(.MAX_CELLS(MAX_CELLS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_push   (push),
      .in_full   (full),
      .in_mode   (req_mode),
      .in_idx    (req_vertex_index),
      .in_height (req_vertex_height),
      .in_x      (req_query_x),
      .in_z      (req_query_z),
      .q_push    (fq_push),
      .q_data    (fq_in),
      .q_full    (fq_full)
   );

   // Queue between front and back.
   htsmp_queue #(.WIDTH($bits(item_type))) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .empty     (fq_empty),
      .pop_data  (fq_out)
   );

   // Back: store access and interpolation.
   htsmp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (fq_empty),
      .q_data   (fq_out),
      .q_pop    (fq_pop),
      .out_push (res_push),
      .out_data (res_in),
      .out_full (res_full)
   );

   // Result queue.
   htsmp_queue #(.WIDTH($bits(result_type))) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (res_out)
   );

   assign rsp_height       = res_out.height;
   assign rsp_outside_grid = res_out.outside_grid;

endmodule
`default_nettype wire

// File: src/htsmp_queue.sv
`default_nettype none
module htsmp_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   // Two-word queue status.
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: src/htsmp_front.sv
`default_nettype none
module htsmp_front #(
   parameter int MAX_CELLS = htsmp_pkg::MAX_CELLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  htsmp_pkg::cfg_type              cfg,
   input  logic                            in_push,
   output logic                            in_full,
   input  logic                            in_mode,
   input  logic [htsmp_pkg::IDX_W-1:0]     in_idx,
   input  logic [htsmp_pkg::H_W-1:0]       in_height,
   input  logic [31:0]                     in_x,
   input  logic [31:0]                     in_z,
   output logic                            q_push,
   output htsmp_pkg::item_type             q_data,
   input  logic                            q_full
);
   import htsmp_pkg::*;

   front_state_type state_ff, state_in;
   logic            loaded_ff;
   logic            negx_ff, negz_ff;
   logic [31:0]     magx_ff, magz_ff;
   logic [63:0]     prodx_ff, prodz_ff;
   logic            accept;

   logic [32:0]     sx, sz;
   logic [31:0]     magx, magz;

   logic [CELL_W-1:0]   cells, gx, gz;
   logic [STRIDE_W-1:0] stride;
   logic [31:0]         cx, cz, cells_ext;
   logic                nx, nz, outside, lower;
   logic [FRAC_W-1:0]   tx, tz;
   logic [WGT_W-1:0]    tsum;
   logic [CELL_W+STRIDE_W-1:0] row_full;
   logic [ADDR_W-1:0]   base;
   item_type            load_item, zero_item, sample_item;

   assign accept = in_push && !in_full;

   // Offset each coordinate by the half extent and take its magnitude.
   always_comb begin
      sx   = {in_x[31], in_x} + {2'b00, cfg.half_extent};
      sz   = {in_z[31], in_z} + {2'b00, cfg.half_extent};
      magx = sx[32] ? 32'(-sx) : sx[31:0];
      magz = sz[32] ? 32'(-sz) : sz[31:0];
   end

   // Grid position of the query and the triangle it falls in.
   always_comb begin
      cells     = ({1'b0, cfg.grid_cells} > CELL_W'(MAX_CELLS)) ?
                  CELL_W'(MAX_CELLS) : {1'b0, cfg.grid_cells};
      stride    = {1'b0, cells} + STRIDE_W'(1);
      cells_ext = 32'(cells);
      cx        = prodx_ff[63:32];
      cz        = prodz_ff[63:32];
      tx        = prodx_ff[31:16];
      tz        = prodz_ff[31:16];
      nx        = negx_ff && (prodx_ff != 64'd0);
      nz        = negz_ff && (prodz_ff != 64'd0);
      outside   = nx || nz || (cx >= cells_ext) || (cz >= cells_ext);
      gx        = nx ? '0 : ((cx > cells_ext) ? cells : cx[CELL_W-1:0]);
      gz        = nz ? '0 : ((cz > cells_ext) ? cells : cz[CELL_W-1:0]);
      row_full  = gz * stride;
      base      = ADDR_W'(row_full) + ADDR_W'(gx);
      tsum      = {1'b0, tx} + {1'b0, tz};
      lower     = !tsum[WGT_W-1];
   end

   // Work items for the back.
   always_comb begin
      load_item           = '0;
      load_item.op        = OP_LOAD;
      load_item.load_idx  = in_idx;
      load_item.load_data = in_height;

      zero_item    = '0;
      zero_item.op = OP_ZERO;

      sample_item         = '0;
      sample_item.op      = OP_SAMPLE;
      sample_item.outside = outside;
      if (outside) begin
         // A clamped query reads one vertex with full weight.
         sample_item.addr[0] = base;
         sample_item.addr[1] = base;
         sample_item.addr[2] = base;
         sample_item.wgt[0]  = WGT_ONE;
      end else if (lower) begin
         sample_item.addr[0] = base;
         sample_item.addr[1] = base + ADDR_W'(stride);
         sample_item.addr[2] = base + ADDR_W'(1);
         sample_item.wgt[0]  = WGT_ONE - tsum;
         sample_item.wgt[1]  = {1'b0, tz};
         sample_item.wgt[2]  = {1'b0, tx};
      end else begin
         sample_item.addr[0] = base + ADDR_W'(stride) + ADDR_W'(1);
         sample_item.addr[1] = base + ADDR_W'(stride);
         sample_item.addr[2] = base + ADDR_W'(1);
         sample_item.wgt[0]  = tsum - WGT_ONE;
         sample_item.wgt[1]  = WGT_ONE - {1'b0, tx};
         sample_item.wgt[2]  = WGT_ONE - {1'b0, tz};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept && in_mode && loaded_ff) begin
               state_in = FR_MULX;
            end
         end
         FR_MULX: state_in = FR_MULZ;
         FR_MULZ: state_in = FR_CLASS;
         FR_CLASS: begin
            if (!q_full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      in_full = 1'b1;
      q_push  = 1'b0;
      q_data  = load_item;
      case (state_ff)
         FR_IDLE: begin
            in_full = q_full;
            if (in_push && !q_full) begin
               if (!in_mode) begin
                  q_push = 1'b1;
                  q_data = load_item;
               end else if (!loaded_ff) begin
                  q_push = 1'b1;
                  q_data = zero_item;
               end
            end
         end
         FR_CLASS: begin
            q_push = 1'b1;
            q_data = sample_item;
         end
         default: begin
            in_full = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FR_IDLE;
         loaded_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && !in_mode) begin
            loaded_ff <= 1'b1;
         end
      end
   end

   // Coordinate magnitudes, then one product per cycle.
   always_ff @(posedge clock) begin
      if (accept && in_mode) begin
         negx_ff <= sx[32];
         negz_ff <= sz[32];
         magx_ff <= magx;
         magz_ff <= magz;
      end
      if (state_ff == FR_MULX) begin
         prodx_ff <= magx_ff * cfg.inv_spacing;
      end
      if (state_ff == FR_MULZ) begin
         prodz_ff <= magz_ff * cfg.inv_spacing;
      end
   end

endmodule
`default_nettype wire

// File: src/htsmp_back.sv
`default_nettype none
module htsmp_back #(
   parameter int MAX_VERTICES = htsmp_pkg::MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  htsmp_pkg::item_type   q_data,
   output logic                  q_pop,
   output logic                  out_push,
   output htsmp_pkg::result_type out_data,
   input  logic                  out_full
);
   import htsmp_pkg::*;

   localparam int MW = $clog2(MAX_VERTICES);

   logic [H_W-1:0] height_store [MAX_VERTICES];

   back_state_type      state_ff, state_in;
   item_type            cur_ff;
   logic [H_W-1:0]      rd_data_ff;
   logic                rd_ok_ff;
   logic signed [49:0]  prod_ff, prod_in;
   logic signed [51:0]  acc_ff, sum;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_ok;
   logic [WGT_W-1:0]    w_sel;
   logic signed [H_W-1:0] rdv;
   logic                wr_en, wr_ok;
   result_type          zero_res, sample_res;

   // Which corner is read and which weight is applied in this step.
   always_comb begin
      rd_addr = cur_ff.addr[0];
      w_sel   = '0;
      case (state_ff)
         BK_RD1: begin
            rd_addr = cur_ff.addr[1];
            w_sel   = cur_ff.wgt[0];
         end
         BK_RD2: begin
            rd_addr = cur_ff.addr[2];
            w_sel   = cur_ff.wgt[1];
         end
         BK_MUL2: w_sel = cur_ff.wgt[2];
         default: rd_addr = cur_ff.addr[0];
      endcase
   end

   assign rd_ok   = {1'b0, rd_addr} < 17'(MAX_VERTICES);
   assign wr_ok   = 17'(q_data.load_idx) < 17'(MAX_VERTICES);
   assign rdv     = rd_ok_ff ? rd_data_ff : '0;
   assign prod_in = rdv * $signed({1'b0, w_sel});

   // Round to nearest with ties upward.
   always_comb begin
      sum                     = acc_ff + 52'(prod_ff) + 52'sd32768;
      sample_res.height       = sum[47:16];
      sample_res.outside_grid = cur_ff.outside;
      zero_res                = '0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_data.op == OP_SAMPLE) begin
               state_in = BK_RD0;
            end
         end
         BK_RD0:  state_in = BK_RD1;
         BK_RD1:  state_in = BK_RD2;
         BK_RD2:  state_in = BK_MUL2;
         BK_MUL2: state_in = BK_DONE;
         BK_DONE: begin
            if (!out_full) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      q_pop    = 1'b0;
      out_push = 1'b0;
      out_data = zero_res;
      wr_en    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               case (q_data.op)
                  OP_LOAD: begin
                     q_pop = 1'b1;
                     wr_en = wr_ok;
                  end
                  OP_ZERO: begin
                     q_pop    = !out_full;
                     out_push = !out_full;
                  end
                  OP_SAMPLE: q_pop = 1'b1;
                  default:   q_pop = 1'b1;
               endcase
            end
         end
         BK_DONE: begin
            out_push = !out_full;
            out_data = sample_res;
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Height store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         height_store[MW'(q_data.load_idx)] <= q_data.load_data;
      end
      rd_data_ff <= height_store[MW'(rd_addr)];
      rd_ok_ff   <= rd_ok;
   end

   // Multiply each corner by its weight and accumulate.
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && q_pop) begin
         cur_ff <= q_data;
      end
      if (state_ff == BK_RD1 || state_ff == BK_RD2 || state_ff == BK_MUL2) begin
         prod_ff <= prod_in;
      end
      if (state_ff == BK_RD2) begin
         acc_ff <= 52'(prod_ff);
      end else if (state_ff == BK_MUL2) begin
         acc_ff <= acc_ff + 52'(prod_ff);
      end
   end

endmodule
`default_nettype wire

// File: src/htsmp_checker.sv
`default_nettype none
module htsmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        req_mode,
   input logic        empty,
   input logic        pop,
   input logic [31:0] rsp_height,
   input logic        rsp_outside_grid
);

   logic [3:0] pending_ff, pending_in;
   logic       loaded_ff;
   logic       q_acc, r_acc;

   assign q_acc = push && !full && req_mode;
   assign r_acc = pop && !empty;

   // Queries accepted whose words have not been taken yet.
   always_comb begin
      pending_in = pending_ff;
      if (q_acc && !r_acc) begin
         pending_in = pending_ff + 4'd1;
      end else if (r_acc && !q_acc) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 4'd0;
         loaded_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (push && !full && !req_mode) begin
            loaded_ff <= 1'b1;
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input side full after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !empty |-> pending_ff != 4'd0)
      else $error("result shown with no query outstanding");

   a_unloaded_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !loaded_ff) |-> (rsp_height == 32'd0 && !rsp_outside_grid))
      else $error("nonzero result before any load");

endmodule

bind heightfield_triangle_sample_top htsmp_checker u_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import htsmp_pkg::*;

   // Scoreboard that mirrors the sampler's state and checks each result word.
   class height_scoreboard;
      logic [31:0] store [int];
      bit          loaded;
      logic [6:0]  cells_reg;
      logic [30:0] half_reg;
      logic [31:0] inv_reg;
      logic [31:0] exp_height [$];
      bit          exp_outside [$];
      int          mismatches;
      int          checked;

      function void reset_state();
         loaded = 0;
         cells_reg = GRID_CELLS_RST;
         half_reg = HALF_EXTENT_RST;
         inv_reg = INV_SPACING_RST;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] v);
         case (idx)
            REG_GRID_CELLS: cells_reg = v[6:0];
            REG_HALF_EXTENT: half_reg = v[30:0];
            default: inv_reg = v;
         endcase
      endfunction

      function logic signed [63:0] vertex(int unsigned a);
         if (a >= 16384 || !store.exists(a)) return 0;
         return $signed(store[a]);
      endfunction

      // Maps a world coordinate to a cell index and a Q0.16 fraction.
      function void map_coord(logic [31:0] c, output bit neg, output logic [63:0] cell_idx,
                              output logic [15:0] frac);
         logic signed [63:0] s;
         logic [63:0] mag, prod;
         s = $signed(c) + $signed({33'd0, half_reg});
         mag = (s < 0) ? -s : s;
         prod = mag * {32'd0, inv_reg};
         neg = (s < 0) && (prod != 0);
         cell_idx = prod >> 32;
         frac = prod[31:16];
      endfunction

      // Notes one accepted input word and predicts its result, if any.
      function void note_word(bit mode, logic [13:0] idx, logic [31:0] hv,
                              logic [31:0] qx, logic [31:0] qz);
         int unsigned cells, stride, gx, gz, base;
         bit nx, nz;
         logic [63:0] cx, cz;
         logic [15:0] tx, tz;
         logic signed [63:0] h00, h10, h01, h11, wx, wz, acc;
         if (!mode) begin
            store[idx] = hv;
            loaded = 1;
            return;
         end
         if (!loaded) begin
            exp_height.push_back(0);
            exp_outside.push_back(0);
            return;
         end
         cells = (cells_reg > 127) ? 127 : cells_reg;
         stride = cells + 1;
         map_coord(qx, nx, cx, tx);
         map_coord(qz, nz, cz, tz);
         if (nx || nz || cx >= cells || cz >= cells) begin
            gx = nx ? 0 : (cx > cells ? cells : cx);
            gz = nz ? 0 : (cz > cells ? cells : cz);
            exp_height.push_back(vertex(gz * stride + gx));
            exp_outside.push_back(1);
            return;
         end
         base = cz * stride + cx;
         h00 = vertex(base);
         h10 = vertex(base + 1);
         h01 = vertex(base + stride);
         h11 = vertex(base + stride + 1);
         wx = tx;
         wz = tz;
         if (wx + wz < 65536)
            acc = h00 * (65536 - wx - wz) + h01 * wz + h10 * wx;
         else
            acc = h11 * (wx + wz - 65536) + h01 * (65536 - wx) + h10 * (65536 - wz);
         // Arithmetic shift gives round half up after the bias.
         acc = (acc + 32768) >>> 16;
         exp_height.push_back(acc[31:0]);
         exp_outside.push_back(0);
      endfunction

      function void check_word(logic [31:0] h, logic o);
         logic [31:0] eh;
         bit eo;
         checked++;
         if (exp_height.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: height %h", h);
            return;
         end
         eh = exp_height.pop_front();
         eo = exp_outside.pop_front();
         if (h !== eh || o !== eo) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result %0d: expected height %h outside %0d, got %h %0d",
                        checked, eh, eo, h, o);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic push = 0, pop = 0;
   logic full, empty;
   logic req_mode = 0;
   logic [13:0] req_vertex_index = 0;
   logic signed [31:0] req_vertex_height = 0, req_query_x = 0, req_query_z = 0;
   logic signed [31:0] rsp_height;
   logic rsp_outside_grid;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   heightfield_triangle_sample_top u_top (.*);

   height_scoreboard sb = new();
   int idle_cycles = 0;
   int queries_sent = 0, loads_sent = 0;
   bit stall_mode = 0;
   localparam int WATCHDOG = 20000;

   initial forever #10 clock = ~clock;

   // Results are checked and inputs counted at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) sb.check_word(rsp_height, rsp_outside_grid);
         if (push && !full) begin
            sb.note_word(req_mode, req_vertex_index, req_vertex_height,
                         req_query_x, req_query_z);
         end
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired with %0d results pending", sb.exp_height.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver stalls on its own pattern, with stall-free stretches.
   always @(negedge clock) begin
      if (($urandom_range(0, 199)) == 0) stall_mode = ~stall_mode;
      pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] v);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= CSR_AW'(4 * idx); pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_reg(idx, v);
   endtask

   // Sends one word; the push stays high while the next word follows directly.
   task automatic send_word(bit m, logic [13:0] i, logic [31:0] h, logic [31:0] x,
                            logic [31:0] z);
      push <= 1; req_mode <= m; req_vertex_index <= i; req_vertex_height <= h;
      req_query_x <= x; req_query_z <= z;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      if (m) queries_sent++; else loads_sent++;
      if ($urandom_range(0, 5) == 0) begin
         push <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   task automatic load_grid(int cells);
      int n;
      n = (cells + 1) * (cells + 1);
      for (int a = 0; a < n; a++) send_word(0, a, $urandom, $urandom, $urandom);
   endtask

   task automatic drain();
      push <= 0;
      while (sb.exp_height.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord(logic [30:0] half);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return $urandom_range(0, 2 * half) - half;
      endcase
   endfunction

   initial begin
      sb.reset_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: queries before any load, then loads at the slot extremes.
      send_word(1, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
      send_word(1, 14'h3fff, 32'hffff_ffff, 0, 0);
      drain();
      csr_write(REG_GRID_CELLS, 2);
      csr_write(REG_HALF_EXTENT, 32'h0001_8000);
      csr_write(REG_INV_SPACING, 32'h0001_0000);
      load_grid(2);
      send_word(0, 14'h3fff, 32'h8000_0000, 0, 0);
      send_word(0, 8, 32'h7fff_ffff, 0, 0);
      send_word(0, 0, 32'h8000_0000, 0, 0);
      send_word(1, 0, 0, 0, 0);
      send_word(1, 0, 0, 32'hffff_0000, 32'hffff_0000);
      send_word(1, 0, 0, 32'h0000_4000, 32'hffff_c000);
      send_word(1, 0, 0, 32'h8000_0000, 32'h8000_0000);
      send_word(1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_word(1, 0, 0, 32'hfffe_8000, 0);
      drain();
      csr_write(REG_GRID_CELLS, 0);
      send_word(1, 0, 0, 0, 0);
      drain();
      csr_write(REG_GRID_CELLS, 2);
      csr_write(REG_INV_SPACING, 0);
      send_word(1, 0, 0, 32'h1234_5678, 32'h8765_4321);
      drain();
      csr_write(REG_INV_SPACING, 32'hffff_ffff);
      csr_write(REG_HALF_EXTENT, 32'h7fff_ffff);
      send_word(1, 0, 0, 0, 32'h8000_0000);
      drain();

      // Random phases: configure, fill the grid, then query with stray loads.
      for (int ph = 0; ph < 8; ph++) begin
         int c, nq;
         logic [30:0] half;
         logic [31:0] inv;
         c = (ph == 1) ? 1 : $urandom_range(1, 12);
         half = $urandom_range(1, 64) << 16;
         inv = ((c << 16) / (2 * (half >> 16))) + $urandom_range(0, 255);
         if (ph == 2) inv = 1;
         csr_write(REG_GRID_CELLS, c);
         csr_write(REG_HALF_EXTENT, half);
         csr_write(REG_INV_SPACING, inv);
         load_grid(c);
         nq = 120;
         for (int q = 0; q < nq; q++) begin
            int n;
            n = (c + 1) * (c + 1);
            if ($urandom_range(0, 9) == 0)
               send_word(0, $urandom_range(0, n - 1), $urandom, $urandom, $urandom);
            else
               send_word(1, $urandom, $urandom, pick_coord(half), pick_coord(half));
         end
         drain();
      end

      $display("Covered %0d loads and %0d queries over several grid settings.",
               loads_sent, queries_sent);
      if (sb.mismatches == 0 && sb.exp_height.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
src/htsmp_pkg.sv
src/htsmp_queue.sv
src/htsmp_front.sv
src/htsmp_back.sv
src/heightfield_triangle_sample_top.sv
src/htsmp_checker.sv
tb/testbench.sv
